// ===== hdl/nntt_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch tracker package
// Shared types, codes and default constants of the touch tracker.
// ----------------------------------------------------------------------------
package nntt_pkg;

	// Default table depth and coordinate width.
	localparam int MAX_TRACKS_DEF = 16;
	localparam int COORD_BITS_DEF = 16;

	// Reset value of the match radius, 27 pixels in sixteenths.
	localparam logic [15:0] RADIUS_RESET = 16'd432;

	// Width of the external coordinate and identifier fields.
	localparam int FIELD_BITS = 16;

	// Result codes.
	typedef enum logic [1:0] {
		EV_ADD    = 2'd0,
		EV_UPDATE = 2'd1,
		EV_REMOVE = 2'd2,
		EV_DROP   = 2'd3
	} event_kind_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RAD,
		ST_SQX,
		ST_SQY,
		ST_FIN,
		ST_DECIDE,
		ST_BLOB,
		ST_END,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	// Controls from the sequencer to the touch table.
	typedef struct packed {
		logic wr;
		logic set_seen;
		logic clr_seen;
		logic load_used;
	} tbl_ctl_t;

endpackage

// ===== hdl/nntt_sqr.sv =====
// ----------------------------------------------------------------------------
// Shared squaring unit
// Squares one operand per cycle; the product is registered.
// ----------------------------------------------------------------------------
module nntt_sqr #(
	parameter int OP_BITS = 16
) (
	input  logic                   clk,
	input  logic [OP_BITS-1:0]     op,
	output logic [2*OP_BITS-1:0]   sq
);

	logic [2*OP_BITS-1:0] sq_q;

	// One multiplication, registered before use.
	always_ff @(posedge clk) begin
		sq_q <= (2*OP_BITS)'(op) * (2*OP_BITS)'(op);
	end

	assign sq = sq_q;

endmodule

// ===== hdl/nntt_table.sv =====
// ----------------------------------------------------------------------------
// Touch table
// Position, identifier and touched mark of each tracked touch. Valid
// entries always form a prefix, so a fill count stands for the valid bits.
// ----------------------------------------------------------------------------
module nntt_table #(
	parameter int MAX_TRACKS = nntt_pkg::MAX_TRACKS_DEF,
	parameter int COORD_BITS = nntt_pkg::COORD_BITS_DEF,
	localparam int IW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1,
	localparam int CW = $clog2(MAX_TRACKS + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  nntt_pkg::tbl_ctl_t          ctl,
	input  logic [IW-1:0]               rd_idx,
	output logic [COORD_BITS-1:0]       rd_x,
	output logic [COORD_BITS-1:0]       rd_y,
	output logic [nntt_pkg::FIELD_BITS-1:0] rd_id,
	output logic                        rd_seen,
	input  logic [IW-1:0]               wr_idx,
	input  logic [COORD_BITS-1:0]       wr_x,
	input  logic [COORD_BITS-1:0]       wr_y,
	input  logic [nntt_pkg::FIELD_BITS-1:0] wr_id,
	input  logic [CW-1:0]               used_val,
	output logic [CW-1:0]               used
);

	logic [COORD_BITS-1:0]           x_q  [MAX_TRACKS];
	logic [COORD_BITS-1:0]           y_q  [MAX_TRACKS];
	logic [nntt_pkg::FIELD_BITS-1:0] id_q [MAX_TRACKS];
	logic [MAX_TRACKS-1:0]           seen_q;
	logic [CW-1:0]                   used_q;

	// Entry payload, written at one address per cycle.
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			x_q[wr_idx]  <= wr_x;
			y_q[wr_idx]  <= wr_y;
			id_q[wr_idx] <= wr_id;
		end
	end

	// Touched marks and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			used_q <= '0;
		end else begin
			if (ctl.clr_seen) begin
				seen_q <= '0;
			end else if (ctl.set_seen) begin
				seen_q[wr_idx] <= 1'b1;
			end
			if (ctl.load_used) begin
				used_q <= used_val;
			end
		end
	end

	// Single read port.
	assign rd_x    = x_q[rd_idx];
	assign rd_y    = y_q[rd_idx];
	assign rd_id   = id_q[rd_idx];
	assign rd_seen = seen_q[rd_idx];
	assign used    = used_q;

endmodule

// ===== hdl/nntt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Touch tracker sequencer
// Steps one blob through the nearest-entry search, the table action and
// the end-of-frame removal pass, and queues the results.
// ----------------------------------------------------------------------------
module nntt_ctrl #(
	parameter int MAX_TRACKS = nntt_pkg::MAX_TRACKS_DEF,
	parameter int COORD_BITS = nntt_pkg::COORD_BITS_DEF,
	localparam int IW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1,
	localparam int CW  = $clog2(MAX_TRACKS + 1),
	localparam int SQW = (COORD_BITS > 16) ? COORD_BITS : 16,
	localparam int DW  = 2 * SQW + 1,
	localparam int FB  = nntt_pkg::FIELD_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,
	input  logic [0:0]            s_tuser,
	input  logic                  s_tlast,
	// Result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [47:0]           m_tdata,
	output logic [1:0]            m_tuser,
	output logic                  m_tlast,
	// Match radius
	input  logic [15:0]           radius,
	// Squaring unit
	output logic [SQW-1:0]        sq_op,
	input  logic [2*SQW-1:0]      sq_res,
	// Touch table
	output nntt_pkg::tbl_ctl_t    tbl_ctl,
	output logic [IW-1:0]         rd_idx,
	input  logic [COORD_BITS-1:0] rd_x,
	input  logic [COORD_BITS-1:0] rd_y,
	input  logic [FB-1:0]         rd_id,
	input  logic                  rd_seen,
	output logic [IW-1:0]         wr_idx,
	output logic [COORD_BITS-1:0] wr_x,
	output logic [COORD_BITS-1:0] wr_y,
	output logic [FB-1:0]         wr_id,
	output logic [CW-1:0]         used_val,
	input  logic [CW-1:0]         used
);

	nntt_pkg::state_t state_q, state_d;

	logic [COORD_BITS-1:0] bx_q, by_q;
	logic                  last_q;
	logic                  in_frame_q, seed_q;
	logic [FB-1:0]         ctr_q;
	logic [IW-1:0]         i_q, best_q;
	logic [CW-1:0]         k_q;
	logic [DW-1:0]         bestd_q;
	logic [2*SQW-1:0]      acc_q, rad2_q;
	logic                  make_new_q;

	// Pending result and output register.
	logic                  pend_v_q;
	nntt_pkg::event_kind_t pend_kind_q;
	logic [FB-1:0]         pend_id_q, pend_x_q, pend_y_q;
	logic                  out_v_q, out_last_q;
	nntt_pkg::event_kind_t out_kind_q;
	logic [FB-1:0]         out_id_q, out_x_q, out_y_q;

	// Combinational helpers.
	logic                  accept, out_free, gen_ok, gen, flush;
	nntt_pkg::event_kind_t gen_kind;
	logic [FB-1:0]         gen_id, gen_x, gen_y;
	logic [COORD_BITS-1:0] in_x, in_y, dx, dy;
	logic [DW-1:0]         dsum;
	logic                  scan_end, seed_start;
	logic [FB-1:0]         new_id;
	logic [CW-1:0]         k_next;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_v_q || m_tready;
	assign gen_ok   = !pend_v_q || out_free;

	assign in_x = COORD_BITS'(s_tdata[15:0]);
	assign in_y = COORD_BITS'(s_tdata[31:16]);
	assign dx   = (bx_q > rd_x) ? (bx_q - rd_x) : (rd_x - bx_q);
	assign dy   = (by_q > rd_y) ? (by_q - rd_y) : (rd_y - by_q);
	assign dsum = DW'(acc_q) + DW'(sq_res);

	assign scan_end   = (CW'(i_q) + CW'(1)) == used;
	assign seed_start = !in_frame_q && (used == '0);
	assign new_id     = seed_q ? ctr_q : ctr_q + FB'(1);
	assign k_next     = rd_seen ? k_q + CW'(1) : k_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nntt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and controls.
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		sq_op    = SQW'(dx);
		tbl_ctl  = '0;
		rd_idx   = i_q;
		wr_idx   = best_q;
		wr_x     = bx_q;
		wr_y     = by_q;
		wr_id    = rd_id;
		used_val = used;
		gen      = 1'b0;
		gen_kind = nntt_pkg::EV_ADD;
		gen_id   = rd_id;
		gen_x    = FB'(bx_q);
		gen_y    = FB'(by_q);
		flush    = 1'b0;
		unique case (state_q)
			nntt_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (accept) begin
					if (s_tuser[0]) begin
						if ((in_frame_q ? seed_q : seed_start) || used == '0) begin
							state_d = nntt_pkg::ST_BLOB;
						end else begin
							state_d = nntt_pkg::ST_RAD;
						end
					end else if (s_tlast) begin
						state_d = nntt_pkg::ST_END;
					end
				end
			end
			nntt_pkg::ST_RAD: begin
				sq_op   = SQW'(radius);
				state_d = nntt_pkg::ST_SQX;
			end
			nntt_pkg::ST_SQX: begin
				sq_op   = SQW'(dx);
				state_d = nntt_pkg::ST_SQY;
			end
			nntt_pkg::ST_SQY: begin
				sq_op   = SQW'(dy);
				state_d = scan_end ? nntt_pkg::ST_FIN : nntt_pkg::ST_SQX;
			end
			nntt_pkg::ST_FIN: begin
				state_d = nntt_pkg::ST_DECIDE;
			end
			nntt_pkg::ST_DECIDE: begin
				state_d = nntt_pkg::ST_BLOB;
			end
			nntt_pkg::ST_BLOB: begin
				rd_idx = best_q;
				if (gen_ok) begin
					gen     = 1'b1;
					state_d = last_q ? nntt_pkg::ST_END : nntt_pkg::ST_FLUSH;
					if (!make_new_q) begin
						// Move the nearest touch to the blob.
						gen_kind         = nntt_pkg::EV_UPDATE;
						tbl_ctl.wr       = 1'b1;
						tbl_ctl.set_seen = 1'b1;
					end else if (used == CW'(MAX_TRACKS)) begin
						gen_kind = nntt_pkg::EV_DROP;
						gen_id   = '0;
					end else begin
						// Append a new touch at the end of the table.
						gen_kind          = nntt_pkg::EV_ADD;
						gen_id            = new_id;
						wr_idx            = IW'(used);
						wr_id             = new_id;
						used_val          = used + CW'(1);
						tbl_ctl.wr        = 1'b1;
						tbl_ctl.set_seen  = 1'b1;
						tbl_ctl.load_used = 1'b1;
					end
				end
			end
			nntt_pkg::ST_END: begin
				if (seed_q || used == '0) begin
					tbl_ctl.clr_seen = 1'b1;
					state_d          = nntt_pkg::ST_FLUSH;
				end else begin
					state_d = nntt_pkg::ST_SCAN;
				end
			end
			nntt_pkg::ST_SCAN: begin
				// Untouched entries leave; touched ones close up in order.
				wr_idx = IW'(k_q);
				wr_x   = rd_x;
				wr_y   = rd_y;
				wr_id  = rd_id;
				if (rd_seen || gen_ok) begin
					if (rd_seen) begin
						tbl_ctl.wr = 1'b1;
					end else begin
						gen      = 1'b1;
						gen_kind = nntt_pkg::EV_REMOVE;
						gen_x    = FB'(rd_x);
						gen_y    = FB'(rd_y);
					end
					if (scan_end) begin
						used_val          = k_next;
						tbl_ctl.load_used = 1'b1;
						tbl_ctl.clr_seen  = 1'b1;
						state_d           = nntt_pkg::ST_FLUSH;
					end
				end
			end
			nntt_pkg::ST_FLUSH: begin
				if (!pend_v_q) begin
					state_d = nntt_pkg::ST_IDLE;
				end else if (out_free) begin
					flush   = 1'b1;
					state_d = nntt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = nntt_pkg::ST_IDLE;
			end
		endcase
	end

	// Frame state and id counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			seed_q     <= 1'b0;
			ctr_q      <= '0;
		end else begin
			if (accept && !in_frame_q) begin
				in_frame_q <= 1'b1;
				seed_q     <= seed_start;
				if (seed_start) begin
					ctr_q <= '0;
				end
			end
			if (tbl_ctl.load_used && state_q == nntt_pkg::ST_BLOB) begin
				ctr_q <= ctr_q + FB'(1);
			end
			if (tbl_ctl.clr_seen) begin
				in_frame_q <= 1'b0;
				seed_q     <= 1'b0;
			end
		end
	end

	// Search datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			nntt_pkg::ST_IDLE: begin
				bx_q       <= in_x;
				by_q       <= in_y;
				last_q     <= s_tlast;
				make_new_q <= 1'b1;
				i_q        <= '0;
			end
			nntt_pkg::ST_SQX: begin
				// Product of the previous step: radius or last dy square.
				if (i_q == '0) begin
					rad2_q <= sq_res;
				end else if (i_q == IW'(1) || dsum < bestd_q) begin
					bestd_q <= dsum;
					best_q  <= i_q - IW'(1);
				end
			end
			nntt_pkg::ST_SQY: begin
				acc_q <= sq_res;
				if (!scan_end) begin
					i_q <= i_q + IW'(1);
				end
			end
			nntt_pkg::ST_FIN: begin
				if (i_q == '0 || dsum < bestd_q) begin
					bestd_q <= dsum;
					best_q  <= i_q;
				end
			end
			nntt_pkg::ST_DECIDE: begin
				make_new_q <= bestd_q > DW'(rad2_q);
			end
			nntt_pkg::ST_END: begin
				i_q <= '0;
				k_q <= '0;
			end
			nntt_pkg::ST_SCAN: begin
				if ((rd_seen || gen_ok) && !scan_end) begin
					i_q <= i_q + IW'(1);
				end
				if (rd_seen) begin
					k_q <= k_next;
				end
			end
			default: begin
			end
		endcase
	end

	// Result queue control: the last result is held back until it is known
	// whether more follow.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if ((gen && pend_v_q) || flush) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			if (gen) begin
				pend_v_q <= 1'b1;
			end else if (flush) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if ((gen && pend_v_q) || flush) begin
			out_kind_q <= pend_kind_q;
			out_id_q   <= pend_id_q;
			out_x_q    <= pend_x_q;
			out_y_q    <= pend_y_q;
			out_last_q <= flush;
		end
		if (gen) begin
			pend_kind_q <= gen_kind;
			pend_id_q   <= gen_id;
			pend_x_q    <= gen_x;
			pend_y_q    <= gen_y;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {out_y_q, out_x_q, out_id_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== hdl/nearest_neighbor_touch_tracker_top.sv =====
// ----------------------------------------------------------------------------
// Nearest-neighbor touch tracker
// Tracks touch blobs from frame to frame and reports add, update, remove
// and drop events.
// ----------------------------------------------------------------------------
// The block takes one blob per transfer and is busy until that blob has been
// handled. A blob that is added to an empty or seeding table skips the search;
// a blob that is matched against a table of N touches is compared with each
// entry, and one shared squaring unit computes dx*dx and dy*dy of each entry
// in turn. The item that closes a tracking frame adds a removal pass that
// walks the table one entry per cycle, so long as the result stream does not
// stall; closing a seed frame skips the pass.
// Results leave one per transfer through an output register; a stalled result
// stream holds the blob step, or the pass at the entry that has to report.
module nearest_neighbor_touch_tracker_top #(
	parameter int MAX_TRACKS = nntt_pkg::MAX_TRACKS_DEF,
	parameter int COORD_BITS = nntt_pkg::COORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // blob_x[15:0], blob_y[31:16]
	input  logic [0:0]  s_tuser,   // blob_present[0]
	input  logic        s_tlast,   // frame_last
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // cursor_id[15:0], cursor_x[31:16], cursor_y[47:32]
	output logic [1:0]  m_tuser,   // event_kind[1:0]
	output logic        m_tlast,   // event_last
	// Match radius register
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	localparam int IW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
	localparam int CW  = $clog2(MAX_TRACKS + 1);
	localparam int SQW = (COORD_BITS > 16) ? COORD_BITS : 16;
	localparam int FB  = nntt_pkg::FIELD_BITS;

	logic [15:0]          radius_q;
	logic [SQW-1:0]       sq_op;
	logic [2*SQW-1:0]     sq_res;
	nntt_pkg::tbl_ctl_t   tbl_ctl;
	logic [IW-1:0]        rd_idx, wr_idx;
	logic [COORD_BITS-1:0] rd_x, rd_y, wr_x, wr_y;
	logic [FB-1:0]        rd_id, wr_id;
	logic                 rd_seen;
	logic [CW-1:0]        used_val, used;

	// Match radius register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= nntt_pkg::RADIUS_RESET;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	nntt_sqr #(
		.OP_BITS (SQW)
	) u_sqr (
		.clk (clk),
		.op  (sq_op),
		.sq  (sq_res)
	);

	nntt_table #(
		.MAX_TRACKS (MAX_TRACKS),
		.COORD_BITS (COORD_BITS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (tbl_ctl),
		.rd_idx   (rd_idx),
		.rd_x     (rd_x),
		.rd_y     (rd_y),
		.rd_id    (rd_id),
		.rd_seen  (rd_seen),
		.wr_idx   (wr_idx),
		.wr_x     (wr_x),
		.wr_y     (wr_y),
		.wr_id    (wr_id),
		.used_val (used_val),
		.used     (used)
	);

	nntt_ctrl #(
		.MAX_TRACKS (MAX_TRACKS),
		.COORD_BITS (COORD_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.radius   (radius_q),
		.sq_op    (sq_op),
		.sq_res   (sq_res),
		.tbl_ctl  (tbl_ctl),
		.rd_idx   (rd_idx),
		.rd_x     (rd_x),
		.rd_y     (rd_y),
		.rd_id    (rd_id),
		.rd_seen  (rd_seen),
		.wr_idx   (wr_idx),
		.wr_x     (wr_x),
		.wr_y     (wr_y),
		.wr_id    (wr_id),
		.used_val (used_val),
		.used     (used)
	);

endmodule

// ===== bench/tb_nearest_neighbor_touch_tracker_top.sv =====
// ----------------------------------------------------------------------------
// Touch tracker testbench
// Streams blob frames into the touch tracker and checks every add, update,
// remove and drop event against a shadow copy of the touch table. A short
// directed sequence covers seeding, ties, empty frames and a full table; then
// random frames run under several match radii with random bursts of idle
// cycles on both streams.
// ----------------------------------------------------------------------------

// One expected result transfer.
typedef struct packed {
	nntt_pkg::event_kind_t kind;
	logic [15:0]           ident;
	logic [15:0]           pos_x;
	logic [15:0]           pos_y;
	logic                  closes;
} cursor_event_t;

// Shadow of the touch table. It works out the events that each accepted blob
// causes and compares the result stream with them in order.
class touch_table_shadow;
	logic [15:0]   radius;
	logic [15:0]   trk_x [nntt_pkg::MAX_TRACKS_DEF];
	logic [15:0]   trk_y [nntt_pkg::MAX_TRACKS_DEF];
	logic [15:0]   trk_id [nntt_pkg::MAX_TRACKS_DEF];
	bit            trk_live [nntt_pkg::MAX_TRACKS_DEF];
	bit            trk_hit [nntt_pkg::MAX_TRACKS_DEF];
	logic [15:0]   id_count;
	bit            framing;
	bit            seeding;
	cursor_event_t staged[$];
	cursor_event_t events_due[$];
	int unsigned   fails;

	function new();
		radius = nntt_pkg::RADIUS_RESET;
		for (int i = 0; i < nntt_pkg::MAX_TRACKS_DEF; i++) begin
			trk_live[i] = 1'b0;
			trk_hit[i] = 1'b0;
		end
		id_count = '0;
		framing = 1'b0;
		seeding = 1'b0;
		fails = 0;
	endfunction

	// Live touches always form a prefix of the table.
	function int live_count();
		int n;
		n = 0;
		while (n < nntt_pkg::MAX_TRACKS_DEF && trk_live[n])
			n++;
		return n;
	endfunction

	function int pending();
		return events_due.size();
	endfunction

	function logic [63:0] sq_gap(logic [15:0] a, logic [15:0] b);
		logic [63:0] g;
		g = (a > b) ? a - b : b - a;
		return g * g;
	endfunction

	function void stage(nntt_pkg::event_kind_t kind, logic [15:0] ident,
			logic [15:0] px, logic [15:0] py);
		cursor_event_t ev;
		ev.kind = kind;
		ev.ident = ident;
		ev.pos_x = px;
		ev.pos_y = py;
		ev.closes = 1'b0;
		staged.insert(staged.size(), ev);
	endfunction

	// Applies one accepted blob transfer to the table.
	function void take_blob(bit present, logic [15:0] bx, logic [15:0] by, bit closes);
		int          used;
		int          best;
		int          keep;
		bit          fresh;
		logic [63:0] gap_sum;
		logic [63:0] best_dist;
		logic [63:0] limit;
		cursor_event_t ev;

		// The first transfer of a frame decides whether the frame seeds the table.
		if (!framing) begin
			framing = 1'b1;
			seeding = (live_count() == 0);
			if (seeding)
				id_count = '0;
		end

		if (present) begin
			fresh = 1'b1;
			best = 0;
			best_dist = '0;
			used = live_count();
			// Nearest live touch, the earliest one winning ties.
			if (!seeding && used > 0) begin
				for (int i = 0; i < used; i++) begin
					gap_sum = sq_gap(bx, trk_x[i]) + sq_gap(by, trk_y[i]);
					if (i == 0 || gap_sum < best_dist) begin
						best_dist = gap_sum;
						best = i;
					end
				end
				limit = {48'd0, radius};
				fresh = best_dist > limit * limit;
			end
			if (!fresh) begin
				trk_x[best] = bx;
				trk_y[best] = by;
				trk_hit[best] = 1'b1;
				stage(nntt_pkg::EV_UPDATE, trk_id[best], bx, by);
			end else if (used >= nntt_pkg::MAX_TRACKS_DEF) begin
				stage(nntt_pkg::EV_DROP, 16'd0, bx, by);
			end else begin
				// Seed frames number from zero; later touches take the next id.
				if (seeding) begin
					trk_id[used] = id_count;
					id_count = id_count + 16'd1;
				end else begin
					id_count = id_count + 16'd1;
					trk_id[used] = id_count;
				end
				trk_live[used] = 1'b1;
				trk_x[used] = bx;
				trk_y[used] = by;
				trk_hit[used] = 1'b1;
				stage(nntt_pkg::EV_ADD, trk_id[used], bx, by);
			end
		end

		// Frame end drops untouched touches and compacts the table in order.
		if (closes) begin
			if (!seeding) begin
				keep = 0;
				used = live_count();
				for (int i = 0; i < used; i++) begin
					if (!trk_hit[i]) begin
						stage(nntt_pkg::EV_REMOVE, trk_id[i], trk_x[i], trk_y[i]);
					end else begin
						trk_x[keep] = trk_x[i];
						trk_y[keep] = trk_y[i];
						trk_id[keep] = trk_id[i];
						keep++;
					end
				end
				for (int i = 0; i < nntt_pkg::MAX_TRACKS_DEF; i++)
					trk_live[i] = (i < keep);
			end
			for (int i = 0; i < nntt_pkg::MAX_TRACKS_DEF; i++)
				trk_hit[i] = 1'b0;
			framing = 1'b0;
			seeding = 1'b0;
		end

		// The last event of this blob carries the closing mark.
		while (staged.size() > 0) begin
			ev = staged.pop_front();
			ev.closes = (staged.size() == 0);
			events_due.insert(events_due.size(), ev);
		end
	endfunction

	// Compares one result transfer with the oldest expected event.
	function void match_event(nntt_pkg::event_kind_t kind, logic [15:0] ident,
			logic [15:0] px, logic [15:0] py, logic closes);
		cursor_event_t want;
		if (events_due.size() == 0) begin
			$error("unexpected result: event_kind %0d cursor_id %0d", kind, ident);
			fails++;
			return;
		end
		want = events_due.pop_front();
		if (kind !== want.kind) begin
			$error("event_kind: expected %0d, actual %0d", want.kind, kind);
			fails++;
		end
		if (ident !== want.ident) begin
			$error("cursor_id: expected %0d, actual %0d", want.ident, ident);
			fails++;
		end
		if (px !== want.pos_x) begin
			$error("cursor_x: expected %0d, actual %0d", want.pos_x, px);
			fails++;
		end
		if (py !== want.pos_y) begin
			$error("cursor_y: expected %0d, actual %0d", want.pos_y, py);
			fails++;
		end
		if (closes !== want.closes) begin
			$error("event_last: expected %0d, actual %0d", want.closes, closes);
			fails++;
		end
	endfunction
endclass

module tb_nearest_neighbor_touch_tracker_top;

	// Longest removal pass plus a full table scan, with margin.
	localparam int SETTLE_CYCLES = 80;
	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 20;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	touch_table_shadow tracker;
	bit                calm;
	int                stall_left;
	int                quiet;

	nearest_neighbor_touch_tracker_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Known values on every input from time zero.
	initial begin
		tracker = new();
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		calm = 1'b0;
		stall_left = 0;
		quiet = 0;
	end

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side stalls in random bursts until the calm part of the run.
	always @(posedge clk) begin
		if (!calm && stall_left == 0 && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(1, 6);
			m_tready <= 1'b0;
		end else if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else begin
			stall_left <= 0;
			m_tready <= 1'b1;
		end
	end

	// Every result transfer is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready)
			tracker.match_event(nntt_pkg::event_kind_t'(m_tuser), m_tdata[15:0],
				m_tdata[31:16], m_tdata[47:32], m_tlast);
	end

	// The run ends if no transfer happens on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("tb_nearest_neighbor_touch_tracker_top failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// Offers one blob and waits for its transfer, idling first at random.
	task automatic send_blob(input bit present, input logic [15:0] bx,
			input logic [15:0] by, input bit closes);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {by, bx};
		s_tuser <= present;
		s_tlast <= closes;
		do @(posedge clk); while (s_tready !== 1'b1);
		tracker.take_blob(present, bx, by, closes);
	endtask

	// Waits until every event has arrived and the block has gone quiet.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_radius(input logic [15:0] r);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.radius = r;
	endtask

	// Moves a coordinate by a small random step, clamped to the field range.
	function automatic logic [15:0] nudge(logic [15:0] v);
		int step;
		int moved;
		step = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400);
		moved = $urandom_range(0, 1) ? int'(v) + step : int'(v) - step;
		if (moved < 0)
			moved = 0;
		if (moved > 65535)
			moved = 65535;
		return moved[15:0];
	endfunction

	// Random frames: mostly blobs close to live touches, some far ones, some
	// empty transfers, and now and then an empty frame that clears the table.
	task automatic run_random_frames(input int target);
		int            sent;
		int            flen;
		int            pick;
		int            used;
		bit            wipe;
		bit            present;
		logic [15:0]   bx;
		logic [15:0]   by;
		sent = 0;
		while (sent < target) begin
			wipe = ($urandom_range(0, 11) == 0);
			flen = wipe ? 1 : $urandom_range(1, 6);
			for (int k = 0; k < flen; k++) begin
				used = tracker.live_count();
				present = !wipe && ($urandom_range(0, 9) != 0);
				if (used > 0 && $urandom_range(0, 99) < 65) begin
					pick = $urandom_range(0, used - 1);
					bx = nudge(tracker.trk_x[pick]);
					by = nudge(tracker.trk_y[pick]);
				end else begin
					bx = 16'($urandom);
					by = 16'($urandom);
				end
				send_blob(present, bx, by, k == flen - 1);
				sent++;
			end
		end
	endtask

	// Main sequence.
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Seed frame on an empty table, with an empty transfer inside.
		send_blob(1'b1, 16'd0, 16'd65535, 1'b0);
		send_blob(1'b1, 16'd2000, 16'd2000, 1'b0);
		send_blob(1'b0, 16'd0, 16'd0, 1'b0);
		send_blob(1'b1, 16'd2500, 16'd2000, 1'b1);
		// Equal distance to two touches picks the earlier one; a far blob adds;
		// an empty closing transfer removes the untouched touches.
		send_blob(1'b1, 16'd2250, 16'd2000, 1'b0);
		send_blob(1'b1, 16'd40000, 16'd100, 1'b0);
		send_blob(1'b0, 16'd65535, 16'd65535, 1'b1);
		// A frame with no blob at all empties the table.
		send_blob(1'b0, 16'd0, 16'd0, 1'b1);
		// Seed a full table, then one more blob is dropped.
		for (int i = 0; i < nntt_pkg::MAX_TRACKS_DEF; i++)
			send_blob(1'b1, 16'(i * 4000), 16'(65535 - i * 4000), 1'b0);
		send_blob(1'b1, 16'd65535, 16'd0, 1'b1);
		// Dropped blob in a tracking frame, then every touch is removed.
		send_blob(1'b1, 16'd30000, 16'd30000, 1'b1);

		set_radius(16'd0);
		run_random_frames(RANDOM_ITEMS);
		set_radius(16'd65535);
		run_random_frames(RANDOM_ITEMS);
		set_radius(16'($urandom_range(1, 65534)));
		run_random_frames(RANDOM_ITEMS);
		set_radius(nntt_pkg::RADIUS_RESET);
		calm = 1'b1;
		run_random_frames(RANDOM_ITEMS);

		drain();
		if (tracker.fails == 0)
			$display("tb_nearest_neighbor_touch_tracker_top passed");
		else
			$display("tb_nearest_neighbor_touch_tracker_top failed");
		$finish;
	end

endmodule
